// ----- rtl/core/nat_csum_pkg.sv -----
package nat_csum_pkg;

	// bytes held back before a byte may leave
	localparam int LINE_DEPTH = 9;
	localparam int CNT_W = $clog2(LINE_DEPTH + 1);

	// header positions
	localparam logic [15:0] POS_VER_IHL = 16'd0;
	localparam logic [15:0] POS_PROTO = 16'd9;
	localparam logic [15:0] POS_ADDR_FIRST = 16'd12;
	localparam logic [15:0] POS_ADDR_LAST = 16'd19;
	localparam logic [15:0] POS_MAX = 16'hFFFF;

	localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam int TCP_CHECK_OFFSET = 16;

	// which checksum a request patches when it enters the line
	typedef enum logic [1:0] {
		PATCH_NONE = 2'd0,
		PATCH_IP   = 2'd1,
		PATCH_TCP  = 2'd2
	} patch_kind_t;

	// one request handed from the classifier to the delay line
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		patch_kind_t patch;
		logic [19:0] adj_sum;
	} queue_cmd_t;

	// ones' complement incremental update of a stored checksum
	function automatic logic [15:0] csum_patch(input logic [15:0] hc, input logic [19:0] adj);
		logic [20:0] s1;
		logic [16:0] s2;
		logic [15:0] s3;
		s1 = {5'd0, ~hc} + {1'b0, adj};
		s2 = {1'b0, s1[15:0]} + {12'd0, s1[20:16]};
		s3 = s2[15:0] + {15'd0, s2[16]};
		return ~s3;
	endfunction

endpackage

// ----- rtl/core/nat_csum_front.sv -----
module nat_csum_front import nat_csum_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_data,
	input  logic       in_last,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output queue_cmd_t cmd
);

	logic        direction_q;
	logic [15:0] pos_q;
	logic [3:0]  hdr_words_q;
	logic [7:0]  proto_q;
	logic [19:0] adj_sum_q;
	logic [7:0]  half_hold_q;

	logic        accept;
	logic [3:0]  hdr_words_d;
	logic [7:0]  proto_d;
	logic [19:0] adj_sum_d;
	logic        in_addr;
	logic [15:0] addr_word;
	logic [19:0] addr_term;
	logic [5:0]  hdr_len;
	logic [6:0]  tcp_pos;
	logic        hdr_ok;

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign accept    = in_valid && cmd_ready;

	// header fields as seen after this byte
	always_comb begin
		hdr_words_d = (pos_q == POS_VER_IHL) ? in_data[3:0] : hdr_words_q;
		proto_d     = (pos_q == POS_PROTO) ? in_data : proto_q;
		in_addr     = (pos_q >= POS_ADDR_FIRST) && (pos_q <= POS_ADDR_LAST);
		addr_word   = {half_hold_q, in_data};
		addr_term   = direction_q ? {4'd0, ~addr_word} : (20'h0FFFF + {4'd0, addr_word});
		adj_sum_d   = adj_sum_q;
		if (in_addr && pos_q[0]) begin
			adj_sum_d = adj_sum_q + addr_term;
		end
	end

	// classify the byte for the delay line
	always_comb begin
		hdr_len     = {hdr_words_d, 2'b00};
		tcp_pos     = {1'b0, hdr_len} + 7'(TCP_CHECK_OFFSET + 1);
		hdr_ok      = hdr_words_d >= MIN_HDR_WORDS;
		cmd.data    = in_data;
		cmd.last    = in_last;
		cmd.adj_sum = adj_sum_d;
		priority if (hdr_ok && pos_q == POS_ADDR_LAST) begin
			cmd.patch = PATCH_IP;
		end else if (hdr_ok && proto_d == PROTO_TCP && pos_q == {9'd0, tcp_pos}) begin
			cmd.patch = PATCH_TCP;
		end else begin
			cmd.patch = PATCH_NONE;
		end
	end

	// packet tracking, cleared at end of packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			pos_q       <= '0;
			hdr_words_q <= '0;
			proto_q     <= '0;
			adj_sum_q   <= '0;
			half_hold_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				direction_q <= cfg_wr_data;
			end
			if (accept) begin
				if (in_last) begin
					pos_q       <= '0;
					hdr_words_q <= '0;
					proto_q     <= '0;
					adj_sum_q   <= '0;
					half_hold_q <= '0;
				end else begin
					if (pos_q != POS_MAX) begin
						pos_q <= pos_q + 16'd1;
					end
					hdr_words_q <= hdr_words_d;
					proto_q     <= proto_d;
					adj_sum_q   <= adj_sum_d;
					if (in_addr && !pos_q[0]) begin
						half_hold_q <= in_data;
					end
				end
			end
		end
	end

endmodule

// ----- rtl/core/nat_csum_queue.sv -----
module nat_csum_queue import nat_csum_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  queue_cmd_t push_cmd,
	output logic       pop_valid,
	input  logic       pop_ready,
	output queue_cmd_t pop_cmd
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	queue_cmd_t       slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = fill_q != FILL_W'(DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/core/nat_csum_back.sv -----
module nat_csum_back import nat_csum_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  queue_cmd_t cmd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_data,
	output logic       out_last
);

	typedef enum logic {
		ST_STREAM,
		ST_FLUSH
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic             out_last_q;
	logic [7:0]       line_q [LINE_DEPTH];
	logic [7:0]       line_d [LINE_DEPTH];
	logic [7:0]       work [LINE_DEPTH + 1];
	logic [15:0]      hc;
	logic [15:0]      fixed;
	logic             emit_ok;
	logic             needs_emit;
	logic             pop;
	logic             emit;
	logic [7:0]       emit_data;
	logic             emit_last;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;
	assign cmd_ready = pop;

	assign emit_ok    = !out_valid_q || out_ready;
	assign needs_emit = cmd.last || (cnt_q == CNT_W'(LINE_DEPTH));
	assign pop        = (state_q == ST_STREAM) && cmd_valid && (!needs_emit || emit_ok);

	// shared checksum patch unit
	assign hc    = (cmd.patch == PATCH_IP) ? {line_q[0], line_q[1]}
	                                       : {line_q[LINE_DEPTH-1], cmd.data};
	assign fixed = csum_patch(hc, cmd.adj_sum);

	// held bytes plus the new one, with any patch applied
	always_comb begin
		for (int k = 0; k < LINE_DEPTH; k++) begin
			work[k] = (cnt_q == CNT_W'(k)) ? cmd.data : line_q[k];
		end
		work[LINE_DEPTH] = cmd.data;
		unique case (cmd.patch)
			PATCH_IP: begin
				work[0] = fixed[15:8];
				work[1] = fixed[7:0];
			end
			PATCH_TCP: begin
				work[LINE_DEPTH-1] = fixed[15:8];
				work[LINE_DEPTH]   = fixed[7:0];
			end
			default: begin
			end
		endcase
	end

	// next line contents, count and emitted byte
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		line_d    = line_q;
		emit      = 1'b0;
		emit_data = work[0];
		emit_last = 1'b0;
		unique case (state_q)
			ST_STREAM: begin
				if (pop) begin
					if (needs_emit) begin
						emit = 1'b1;
						for (int k = 0; k < LINE_DEPTH; k++) begin
							line_d[k] = work[k+1];
						end
						if (cmd.last) begin
							emit_last = cnt_q == '0;
							if (cnt_q != '0) begin
								state_d = ST_FLUSH;
							end
						end
					end else begin
						for (int k = 0; k < LINE_DEPTH; k++) begin
							line_d[k] = work[k];
						end
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				emit_data = line_q[0];
				if (emit_ok) begin
					emit      = 1'b1;
					emit_last = cnt_q == CNT_W'(1);
					for (int k = 0; k < LINE_DEPTH - 1; k++) begin
						line_d[k] = line_q[k+1];
					end
					cnt_d = cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_d = ST_STREAM;
					end
				end
			end
			default: begin
				state_d = ST_STREAM;
			end
		endcase
	end

	// control state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_STREAM;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				out_valid_q <= 1'b1;
				out_data_q  <= emit_data;
				out_last_q  <= emit_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// delay line storage
	always_ff @(posedge clk) begin
		line_q <= line_d;
	end

endmodule

// ----- rtl/core/ipv4_nat_checksum_fixup.sv -----
// IPv4 checksum fixup for address insertion or removal. Packet bytes stream in one per
// cycle while the output keeps up and leave in the same order after a nine-byte hold, with
// the IPv4 header checksum (bytes 10-11) and, for TCP, the TCP checksum at header length
// plus 16 adjusted for the source and destination addresses (bytes 12-19) being inserted
// in place of zero (cfg_wr_data 0) or replaced by zero (cfg_wr_data 1). Packets shorter
// than 20 bytes, header lengths below 20 bytes and a TCP checksum not wholly inside the
// packet go through unchanged. Throughput is one byte per cycle within a packet when the
// output does not stall; at the last byte the hold drains one byte per cycle, again unless
// the output stalls, and takes no new bytes until it is empty, the drain being paced by the
// single output register. A small request queue between the classifier and the delay line
// absorbs short output stalls. Change direction only between packets.
module ipv4_nat_checksum_fixup import nat_csum_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast
);

	queue_cmd_t front_cmd;
	queue_cmd_t back_cmd;
	logic       front_valid;
	logic       front_ready;
	logic       back_valid;
	logic       back_ready;

	// classifier: position, header fields, address sum
	nat_csum_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_data     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.cmd_valid   (front_valid),
		.cmd_ready   (front_ready),
		.cmd         (front_cmd)
	);

	// request queue
	nat_csum_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	// delay line, patching and drain
	nat_csum_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
